/* hw/rtl/mclb_pkg.sv */
// Shared types, codes and helper functions of the LED mode blinker.
package mclb_pkg;

	// Input command codes
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_OFF     = 3'd1;
	localparam logic [2:0] CMD_CONST   = 3'd2;
	localparam logic [2:0] CMD_BREATHE = 3'd3;
	localparam logic [2:0] CMD_BLINK   = 3'd4;

	// Drive codes on the result
	localparam logic [1:0] DRIVE_DARK    = 2'd0;
	localparam logic [1:0] DRIVE_CONST   = 2'd1;
	localparam logic [1:0] DRIVE_BREATHE = 2'd2;

	localparam logic [6:0] PCT_MAX     = 7'd100;
	localparam logic [3:0] MAX_RESULTS = 4'd8;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_CONST,
		MODE_BREATHE,
		MODE_BLINK
	} chan_mode_t;

	typedef enum logic [2:0] {
		ITEM_TICK,
		ITEM_OFF,
		ITEM_CONST,
		ITEM_BREATHE,
		ITEM_BLINK
	} item_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_FLUSH
	} back_state_t;

	// One classified request as it travels through the queue.
	typedef struct packed {
		item_kind_t  kind;
		logic [3:0]  ch;
		logic [6:0]  pct;
		logic [7:0]  dv;
		logic [14:0] on_len;
		logic [14:0] off_len;
	} item_t;

	typedef struct packed {
		chan_mode_t  mode;
		logic [6:0]  pct;
		logic [7:0]  dv;
		logic [14:0] on_len;
		logic [14:0] off_len;
		logic [15:0] count;
		logic        lit;
	} chan_rec_t;

	typedef struct packed {
		logic [2:0] out_channel;
		logic [1:0] drive;
		logic [6:0] level;
		logic [7:0] breathe_div;
	} result_t;

	typedef struct packed {
		chan_rec_t rec;
		logic      toggled;
	} tick_step_t;

	localparam chan_rec_t REC_RESET = '{
		mode: MODE_OFF, pct: 7'd0, dv: 8'd1, on_len: 15'd0,
		off_len: 15'd0, count: 16'd0, lit: 1'b0
	};

	// Drive setting that a channel record shows.
	function automatic result_t drive_of(chan_rec_t r, logic [3:0] ch);
		result_t res;
		res.out_channel = ch[2:0];
		res.drive       = DRIVE_DARK;
		res.level       = 7'd0;
		res.breathe_div = 8'd0;
		unique case (r.mode)
			MODE_CONST: begin
				res.drive = DRIVE_CONST;
				res.level = r.pct;
			end
			MODE_BREATHE: begin
				res.drive       = DRIVE_BREATHE;
				res.breathe_div = r.dv;
			end
			MODE_BLINK: begin
				if (r.lit) begin
					res.drive = DRIVE_CONST;
					res.level = r.pct;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Advances one channel record by one tick.
	function automatic tick_step_t tick_of(chan_rec_t r);
		tick_step_t st;
		logic [15:0] cnt;
		st.rec     = r;
		st.toggled = 1'b0;
		cnt        = r.count - 16'd1;
		if (r.mode == MODE_BLINK) begin
			if (cnt == 16'd0) begin
				st.toggled   = 1'b1;
				st.rec.lit   = ~r.lit;
				st.rec.count = r.lit ? {1'b0, r.off_len} : {1'b0, r.on_len};
			end else begin
				st.rec.count = cnt;
			end
		end
		return st;
	endfunction

endpackage

/* hw/rtl/mclb_front.sv */
// Front end: accepts requests, drops the void ones and normalizes arguments.
module mclb_front import mclb_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [3:0]  channel,
	input  logic [7:0]  percent,
	input  logic [7:0]  divider,
	input  logic [15:0] on_ms,
	input  logic [15:0] off_ms,
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  keep;
	item_t item_d;
	logic  in_range;
	logic  accept;

	assign in_range = {1'b0, channel} < 5'(NUM_CHANNELS);
	assign busy     = valid_s1 & q_full;
	assign accept   = start & ~busy;
	assign q_push   = valid_s1 & ~q_full;
	assign q_item   = item_s1;

	always_comb begin
		item_d.kind    = ITEM_TICK;
		item_d.ch      = channel;
		item_d.pct     = (percent > {1'b0, PCT_MAX}) ? PCT_MAX : percent[6:0];
		item_d.dv      = divider;
		item_d.on_len  = on_ms[15:1];
		item_d.off_len = off_ms[15:1];
		keep           = 1'b0;
		unique case (cmd)
			CMD_TICK: begin
				keep = 1'b1;
			end
			CMD_OFF: begin
				item_d.kind = ITEM_OFF;
				keep        = in_range;
			end
			CMD_CONST: begin
				item_d.kind = ITEM_CONST;
				keep        = in_range;
			end
			CMD_BREATHE: begin
				item_d.kind = ITEM_BREATHE;
				keep        = in_range && divider != 8'd0;
			end
			CMD_BLINK: begin
				item_d.kind = ITEM_BLINK;
				keep        = in_range && on_ms != 16'd0 && off_ms != 16'd0;
			end
			default: keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* hw/rtl/mclb_queue.sv */
// Two-entry request queue between the front end and the channel engine.
module mclb_queue import mclb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign empty = fill_q == '0;
	assign full  = fill_q == (PTR_W + 1)'(DEPTH);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hw/rtl/mclb_back.sv */
// Channel engine: holds the mode records, applies commands and walks ticks.
module mclb_back import mclb_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  item_t   q_head,
	output logic    q_pop,
	output logic    res_valid,
	output logic    res_last,
	output result_t res
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

	back_state_t      state_q, state_d;
	chan_rec_t        recs_q [NUM_CHANNELS];
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [3:0]       found_q, found_d;
	logic             pend_valid_q, pend_valid_d;
	result_t          pend_q, pend_d;

	logic [IDX_W-1:0] rd_idx;
	chan_rec_t        rec;
	chan_rec_t        rec_new;
	logic             rec_we;
	tick_step_t       step;
	logic             emit;
	logic             emit_last;
	result_t          emit_res;
	logic             act;

	assign rd_idx = (state_q == BK_IDLE) ? q_head.ch[IDX_W-1:0] : idx_q;
	assign rec    = recs_q[rd_idx];
	assign step   = tick_of(rec);

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		found_d      = found_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		q_pop        = 1'b0;
		rec_we       = 1'b0;
		rec_new      = rec;
		emit         = 1'b0;
		emit_last    = 1'b0;
		emit_res     = pend_q;
		act          = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (q_head.kind)
						ITEM_TICK: begin
							state_d      = BK_WALK;
							idx_d        = '0;
							found_d      = '0;
							pend_valid_d = 1'b0;
						end
						ITEM_OFF: begin
							act          = rec.mode != MODE_OFF;
							rec_new.mode = MODE_OFF;
						end
						ITEM_CONST: begin
							act          = !(rec.mode == MODE_CONST && rec.pct == q_head.pct);
							rec_new.mode = MODE_CONST;
							rec_new.pct  = q_head.pct;
						end
						ITEM_BREATHE: begin
							act          = !(rec.mode == MODE_BREATHE && rec.dv == q_head.dv);
							rec_new.mode = MODE_BREATHE;
							rec_new.dv   = q_head.dv;
							if (rec.pct == 7'd0) begin
								rec_new.pct = PCT_MAX;
							end
						end
						default: begin
							act = !(rec.mode == MODE_BLINK && rec.pct == q_head.pct &&
								rec.on_len == q_head.on_len &&
								rec.off_len == q_head.off_len);
							rec_new.mode    = MODE_BLINK;
							rec_new.pct     = q_head.pct;
							rec_new.on_len  = q_head.on_len;
							rec_new.off_len = q_head.off_len;
							rec_new.count   = {1'b0, q_head.on_len};
							rec_new.lit     = 1'b1;
						end
					endcase
					if (act) begin
						rec_we    = 1'b1;
						emit      = 1'b1;
						emit_last = 1'b1;
						emit_res  = drive_of(rec_new, q_head.ch);
					end
				end
			end
			BK_WALK: begin
				rec_we  = 1'b1;
				rec_new = step.rec;
				// A result is held back one find so that the final one can carry last.
				if (step.toggled && found_q < MAX_RESULTS) begin
					found_d      = found_q + 4'd1;
					pend_valid_d = 1'b1;
					pend_d       = drive_of(step.rec, 4'(idx_q));
					emit         = pend_valid_q;
				end
				if (idx_q == IDX_LAST) begin
					state_d = BK_FLUSH;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			BK_FLUSH: begin
				emit      = pend_valid_q;
				emit_last = 1'b1;
				state_d   = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			idx_q        <= '0;
			found_q      <= '0;
			pend_valid_q <= 1'b0;
			res_valid    <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				recs_q[i] <= REC_RESET;
			end
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			found_q      <= found_d;
			pend_valid_q <= pend_valid_d;
			res_valid    <= emit;
			if (rec_we) begin
				recs_q[rd_idx] <= rec_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (emit) begin
			res      <= emit_res;
			res_last <= emit_last;
		end
	end

endmodule

/* hw/rtl/multi_channel_led_mode_blinker.sv */
// Top level of the multi-channel LED mode blinker.
//
//   channel   direction  handshake            fields
//   request   in         start / busy         cmd, channel, percent, divider, on_ms, off_ms
//   result    out        result_valid strobe  out_channel, drive, level, breathe_div, last
//
// A request is registered in the front end, passes a two-entry queue and is
// executed by the channel engine. A mode command is applied in the idle state of
// the engine and gives at most one result, which the engine output registers. A
// tick walks the channel records one per cycle and then flushes its held result.
// busy rises only when the front stage and the queue are both full.
// Reset sets every channel off with divider one and gives no result.
module multi_channel_led_mode_blinker import mclb_pkg::*; #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [3:0]  channel,
	input  logic [7:0]  percent,
	input  logic [7:0]  divider,
	input  logic [15:0] on_ms,
	input  logic [15:0] off_ms,
	output logic        result_valid,
	output logic [2:0]  out_channel,
	output logic [1:0]  drive,
	output logic [6:0]  level,
	output logic [7:0]  breathe_div,
	output logic        last
);

	logic    q_full;
	logic    q_empty;
	logic    q_push;
	logic    q_pop;
	item_t   q_item;
	item_t   q_head;
	result_t res;

	mclb_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.channel(channel),
		.percent(percent),
		.divider(divider),
		.on_ms  (on_ms),
		.off_ms (off_ms),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_item)
	);

	mclb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_item),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	mclb_back #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.res_valid(result_valid),
		.res_last (last),
		.res      (res)
	);

	assign out_channel = res.out_channel;
	assign drive       = res.drive;
	assign level       = res.level;
	assign breathe_div = res.breathe_div;

endmodule

/* tb/tb_multi_channel_led_mode_blinker.sv */
// Self-checking testbench of the multi-channel LED mode blinker.
`timescale 1ns / 100ps

module tb_multi_channel_led_mode_blinker;
	import mclb_pkg::*;

	localparam int NUM_CH = 8;
	localparam int ITEMS_PER_PHASE = 29;
	localparam int MAX_DRIVES = MAX_RESULTS;
	localparam logic [2:0] CMD_LAST_CODE = 3'd7;
	localparam logic [3:0] CHAN_FIELD_MAX = 4'd15;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  channel;
		logic [7:0]  percent;
		logic [7:0]  divider;
		logic [15:0] on_ms;
		logic [15:0] off_ms;
		logic        settle;
	} led_req_t;

	typedef struct packed {
		logic [2:0] out_channel;
		logic [1:0] drive;
		logic [6:0] level;
		logic [7:0] breathe_div;
		logic       last;
	} led_drive_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  cmd = CMD_TICK;
	logic [3:0]  channel = 4'd0;
	logic [7:0]  percent = 8'd0;
	logic [7:0]  divider = 8'd0;
	logic [15:0] on_ms = 16'd0;
	logic [15:0] off_ms = 16'd0;
	logic        result_valid;
	logic [2:0]  out_channel;
	logic [1:0]  drive;
	logic [6:0]  level;
	logic [7:0]  breathe_div;
	logic        last;

	multi_channel_led_mode_blinker #(.NUM_CHANNELS(NUM_CH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.channel(channel),
		.percent(percent),
		.divider(divider),
		.on_ms(on_ms),
		.off_ms(off_ms),
		.result_valid(result_valid),
		.out_channel(out_channel),
		.drive(drive),
		.level(level),
		.breathe_div(breathe_div),
		.last(last)
	);

	// Predicted channel records.
	chan_mode_t  led_mode [NUM_CH];
	logic [6:0]  led_pct [NUM_CH];
	logic [7:0]  led_div [NUM_CH];
	logic [14:0] on_ticks [NUM_CH];
	logic [14:0] off_ticks [NUM_CH];
	logic [15:0] phase_cnt [NUM_CH];
	logic        lit [NUM_CH];

	led_req_t   pend_q [$];
	led_drive_t drive_exp_q [$];
	int         sender_idle_pct = 22;
	int         fail_cnt = 0;
	logic       req_taken = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_multi_channel_led_mode_blinker failed");
		$finish;
	end

	function automatic led_drive_t chan_drive(int ch);
		led_drive_t d;
		d = '0;
		d.out_channel = ch[2:0];
		d.drive = DRIVE_DARK;
		case (led_mode[ch])
			MODE_CONST: begin
				d.drive = DRIVE_CONST;
				d.level = led_pct[ch];
			end
			MODE_BREATHE: begin
				d.drive = DRIVE_BREATHE;
				d.breathe_div = led_div[ch];
			end
			MODE_BLINK: begin
				if (lit[ch]) begin
					d.drive = DRIVE_CONST;
					d.level = led_pct[ch];
				end
			end
			default: ;
		endcase
		return d;
	endfunction

	task automatic predict_request(input led_req_t r);
		led_drive_t  res [MAX_DRIVES];
		int          n;
		int          ch;
		logic        changed;
		logic [6:0]  pct;
		logic [14:0] on_t;
		logic [14:0] off_t;
		n = 0;
		changed = 1'b0;
		ch = r.channel;
		pct = (r.percent > PCT_MAX) ? PCT_MAX : r.percent[6:0];
		on_t = r.on_ms[15:1];
		off_t = r.off_ms[15:1];
		if (r.cmd == CMD_TICK) begin
			for (int i = 0; i < NUM_CH; i++) begin
				if (led_mode[i] == MODE_BLINK) begin
					phase_cnt[i] = phase_cnt[i] - 16'd1;
					if (phase_cnt[i] == 16'd0) begin
						lit[i] = ~lit[i];
						phase_cnt[i] = lit[i] ? {1'b0, on_ticks[i]} : {1'b0, off_ticks[i]};
						if (n < MAX_DRIVES) begin
							res[n] = chan_drive(i);
							n++;
						end
					end
				end
			end
		end else if (r.cmd <= CMD_BLINK && ch < NUM_CH) begin
			case (r.cmd)
				CMD_OFF: begin
					if (led_mode[ch] != MODE_OFF) begin
						led_mode[ch] = MODE_OFF;
						changed = 1'b1;
					end
				end
				CMD_CONST: begin
					if (!(led_mode[ch] == MODE_CONST && led_pct[ch] == pct)) begin
						led_mode[ch] = MODE_CONST;
						led_pct[ch] = pct;
						changed = 1'b1;
					end
				end
				CMD_BREATHE: begin
					if (r.divider != 8'd0 &&
					    !(led_mode[ch] == MODE_BREATHE && led_div[ch] == r.divider)) begin
						led_mode[ch] = MODE_BREATHE;
						led_div[ch] = r.divider;
						// A dark channel picks up full brightness.
						if (led_pct[ch] == 7'd0)
							led_pct[ch] = PCT_MAX;
						changed = 1'b1;
					end
				end
				default: begin
					if (r.on_ms != 16'd0 && r.off_ms != 16'd0 &&
					    !(led_mode[ch] == MODE_BLINK && led_pct[ch] == pct &&
					      on_ticks[ch] == on_t && off_ticks[ch] == off_t)) begin
						led_mode[ch] = MODE_BLINK;
						led_pct[ch] = pct;
						on_ticks[ch] = on_t;
						off_ticks[ch] = off_t;
						phase_cnt[ch] = {1'b0, on_t};
						lit[ch] = 1'b1;
						changed = 1'b1;
					end
				end
			endcase
			if (changed) begin
				res[0] = chan_drive(ch);
				n = 1;
			end
		end
		for (int k = 0; k < n; k++) begin
			res[k].last = (k == n - 1);
			drive_exp_q.push_back(res[k]);
		end
	endtask

	function automatic led_req_t make_req(logic [2:0] c, logic [3:0] ch, logic [7:0] pct,
	                                      logic [7:0] dv, logic [15:0] onm, logic [15:0] offm);
		led_req_t r;
		r = '0;
		r.cmd = c;
		r.channel = ch;
		r.percent = pct;
		r.divider = dv;
		r.on_ms = onm;
		r.off_ms = offm;
		return r;
	endfunction

	// Mostly well-formed commands on valid channels with short blink times,
	// plus some noise that the block must drop.
	function automatic led_req_t random_request();
		led_req_t r;
		int pick;
		r = '0;
		pick = $urandom_range(0, 99);
		r.channel = 4'($urandom_range(0, NUM_CH - 1));
		r.percent = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
		r.divider = 8'($urandom_range(1, 255));
		r.on_ms = 16'($urandom_range(1, 10));
		r.off_ms = 16'($urandom_range(1, 10));
		if ($urandom_range(0, 7) == 0) begin
			r.on_ms = 16'($urandom);
			r.off_ms = 16'($urandom);
		end
		if (pick < 40)
			r.cmd = CMD_TICK;
		else if (pick < 50)
			r.cmd = CMD_OFF;
		else if (pick < 62)
			r.cmd = CMD_CONST;
		else if (pick < 70)
			r.cmd = CMD_BREATHE;
		else if (pick < 90)
			r.cmd = CMD_BLINK;
		else begin
			case ($urandom_range(0, 3))
				0: begin
					r.cmd = 3'($urandom_range(CMD_BLINK + 3'd1, CMD_LAST_CODE));
					r.channel = 4'($urandom);
				end
				1: begin
					r.cmd = 3'($urandom_range(CMD_OFF, CMD_BLINK));
					r.channel = 4'($urandom_range(NUM_CH, CHAN_FIELD_MAX));
				end
				2: begin
					r.cmd = CMD_BREATHE;
					r.divider = 8'd0;
				end
				default: begin
					r.cmd = CMD_BLINK;
					if ($urandom_range(0, 1) == 0)
						r.on_ms = 16'd0;
					else
						r.off_ms = 16'd0;
				end
			endcase
		end
		return r;
	endfunction

	// Request driver: a request stays on the ports until it is taken.
	always @(negedge clk) begin
		if (!arst_n)
			start <= 1'b0;
		else if (!start || req_taken) begin
			if (pend_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct &&
			    !(pend_q[0].settle && drive_exp_q.size() != 0)) begin
				cmd <= pend_q[0].cmd;
				channel <= pend_q[0].channel;
				percent <= pend_q[0].percent;
				divider <= pend_q[0].divider;
				on_ms <= pend_q[0].on_ms;
				off_ms <= pend_q[0].off_ms;
				start <= 1'b1;
				void'(pend_q.pop_front());
			end else
				start <= 1'b0;
		end
	end

	// Result checker and predictor.
	always @(posedge clk) begin
		led_drive_t e;
		led_req_t   r;
		req_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (result_valid) begin
				if (drive_exp_q.size() == 0) begin
					$error("unexpected result on channel %0d", out_channel);
					fail_cnt++;
				end else begin
					e = drive_exp_q.pop_front();
					if (out_channel !== e.out_channel) begin
						$error("out_channel: expected %0d, got %0d", e.out_channel, out_channel);
						fail_cnt++;
					end
					if (drive !== e.drive) begin
						$error("drive: expected %0d, got %0d", e.drive, drive);
						fail_cnt++;
					end
					if (level !== e.level) begin
						$error("level: expected %0d, got %0d", e.level, level);
						fail_cnt++;
					end
					if (breathe_div !== e.breathe_div) begin
						$error("breathe_div: expected %0d, got %0d", e.breathe_div, breathe_div);
						fail_cnt++;
					end
					if (last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last);
						fail_cnt++;
					end
				end
			end
			if (start && !busy) begin
				r = make_req(cmd, channel, percent, divider, on_ms, off_ms);
				predict_request(r);
			end
		end
	end

	initial begin
		led_req_t req;
		led_req_t prev;
		int counted;
		for (int i = 0; i < NUM_CH; i++) begin
			led_mode[i] = MODE_OFF;
			led_pct[i] = 7'd0;
			led_div[i] = 8'd1;
			on_ticks[i] = 15'd0;
			off_ticks[i] = 15'd0;
			phase_cnt[i] = 16'd0;
			lit[i] = 1'b0;
		end
		prev = '0;

		// Directed requests.
		pend_q.push_back(make_req(CMD_TICK, 4'd0, 8'd0, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_OFF, 4'd0, 8'd0, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_CONST, 4'd0, 8'd255, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_CONST, 4'd0, 8'd100, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_CONST, 4'd1, 8'd0, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_CONST, 4'd8, 8'd50, 8'd9, 16'd4, 16'd4));
		pend_q.push_back(make_req(CMD_OFF, CHAN_FIELD_MAX, 8'd0, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_BREATHE, 4'd2, 8'd0, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_BREATHE, 4'd2, 8'd0, 8'd255, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_BREATHE, 4'd2, 8'd0, 8'd255, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_BLINK, 4'd3, 8'd40, 8'd0, 16'd0, 16'd4));
		pend_q.push_back(make_req(CMD_BLINK, 4'd3, 8'd40, 8'd0, 16'd4, 16'd0));
		pend_q.push_back(make_req(CMD_BLINK, 4'd3, 8'd0, 8'd0, 16'd4, 16'd2));
		pend_q.push_back(make_req(CMD_BLINK, 4'd3, 8'd0, 8'd0, 16'd4, 16'd2));
		pend_q.push_back(make_req(CMD_BLINK, 4'd4, 8'd77, 8'd0, 16'd1, 16'hFFFF));
		pend_q.push_back(make_req(CMD_BLINK, 4'd2, 8'd255, 8'd0, 16'hFFFF, 16'd3));
		pend_q.push_back(make_req(CMD_BLINK + 3'd1, 4'd1, 8'd10, 8'd1, 16'd2, 16'd2));
		pend_q.push_back(make_req(CMD_LAST_CODE, CHAN_FIELD_MAX, 8'd255, 8'd255,
		                          16'hFFFF, 16'hFFFF));
		req = make_req(CMD_TICK, 4'd0, 8'd0, 8'd0, 16'd0, 16'd0);
		req.settle = 1'b1;
		pend_q.push_back(req);
		repeat (4) pend_q.push_back(make_req(CMD_TICK, 4'd0, 8'd0, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_OFF, 4'd3, 8'd0, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_CONST, 4'd5, 8'd101, 8'd0, 16'd0, 16'd0));
		pend_q.push_back(make_req(CMD_BREATHE, 4'd1, 8'd0, 8'd1, 16'd0, 16'd0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			while (pend_q.size() != 0) @(posedge clk);
			sender_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 57 : 0;
			if (phase == 2) begin
				// Every channel toggles on every tick: full bursts of results.
				for (int ch = 0; ch < NUM_CH; ch++)
					pend_q.push_back(make_req(CMD_BLINK, 4'(ch), 8'($urandom), 8'd0,
					                          16'd2, 16'd3));
				repeat (4) pend_q.push_back(make_req(CMD_TICK, 4'd0, 8'd0, 8'd0, 16'd0, 16'd0));
			end
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				if (counted != 0 && $urandom_range(0, 9) == 0)
					req = prev;
				else
					req = random_request();
				req.settle = (phase == 1 && counted == 0);
				pend_q.push_back(req);
				if (req.cmd <= CMD_BLINK && req.channel < NUM_CH)
					counted++;
				prev = req;
			end
		end

		while (pend_q.size() != 0 || start) @(posedge clk);
		while (drive_exp_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb_multi_channel_led_mode_blinker passed");
		else
			$display("tb_multi_channel_led_mode_blinker failed");
		$finish;
	end

endmodule
